// ===== design/two_ended_mark_release_allocator_assert.svh =====
// Assertion helpers shared by the allocator modules.
// Both expect aclk and aresetn in scope.
`ifndef TWO_ENDED_MARK_RELEASE_ALLOCATOR_ASSERT_SVH
`define TWO_ENDED_MARK_RELEASE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication
`define TEMA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TEMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tema_pkg.sv =====
package tema_pkg;

    // Sizing
    localparam int MARK_DEPTH  = 16;
    localparam int ALIGN_BYTES = 8;
    localparam int ALIGN_LOG2  = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 0;
    localparam int ADDR_W      = 32;
    localparam int REQ_W       = 32;
    localparam int CFG_W       = 32;
    localparam int PADDR_W     = 3;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int CNT_W       = $clog2(MARK_DEPTH + 1);
    localparam int IDX_W       = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;

    // Register map: index taken from paddr bit 2
    localparam logic REG_BASE   = 1'b0;
    localparam logic REG_REGION = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_MARK    = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_ZERO   = 3'd1,
        ST_NOROOM = 3'd2,
        ST_WRAP   = 3'd3,
        ST_FULL   = 3'd4,
        ST_EMPTY  = 3'd5
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stk_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } stk_stat_t;

endpackage

// ===== design/tema_mark_stack.sv =====
`include "two_ended_mark_release_allocator_assert.svh"

module tema_mark_stack (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tema_pkg::stk_cmd_t            cmd,
    input  logic [tema_pkg::ADDR_W-1:0]   push_data,
    output logic [tema_pkg::ADDR_W-1:0]   pop_data,
    output tema_pkg::stk_stat_t           stat
);
    import tema_pkg::*;

    logic [ADDR_W-1:0] mark_reg [MARK_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  count_dec;
    logic [IDX_W-1:0]  push_idx;
    logic [IDX_W-1:0]  pop_idx;

    // Entry at the top of the stack and the next free slot
    assign count_dec = count_reg - CNT_W'(1);
    assign push_idx  = count_reg[IDX_W-1:0];
    assign pop_idx   = count_dec[IDX_W-1:0];
    assign pop_data  = mark_reg[pop_idx];

    assign stat.full  = (count_reg == CNT_W'(MARK_DEPTH));
    assign stat.empty = (count_reg == '0);

    // Advance the fill count
    always_comb begin
        count_next = count_reg;
        if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Store the pushed pointer; entries hold no reset value
    always_ff @(posedge aclk) begin
        if (cmd.push && !cmd.clear) begin
            mark_reg[push_idx] <= push_data;
        end
    end

    `TEMA_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MARK_DEPTH), "mark count overflow")
    `TEMA_ASSERT_NOW(a_no_push_full, cmd.push, !stat.full, "push into full mark stack")
    `TEMA_ASSERT_NOW(a_no_pop_empty, cmd.pop, !stat.empty, "pop from empty mark stack")

endmodule

// ===== design/two_ended_mark_release_allocator.sv =====
// Flow: an accepted beat is captured in the input register, computed into the result
// register and held on m_valid until m_ready takes it. Throughput: one request per cycle
// unless the result stage stalls; the pointer and mark-count registers are read and
// updated by the single compute stage, so back-to-back requests see each other's effect.
// Reset: synchronous, active-low aresetn clears base, size, both pointers and both mark
// counts; stored mark entries keep whatever they held.
`include "two_ended_mark_release_allocator_assert.svh"

module two_ended_mark_release_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tema_pkg::PADDR_W-1:0]    paddr,
    input  logic [tema_pkg::CFG_W-1:0]      pwdata,
    output logic [tema_pkg::CFG_W-1:0]      prdata,
    output logic                            pready,
    // Request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tema_pkg::OP_W-1:0]       s_op,
    input  logic                            s_from_top,
    input  logic [tema_pkg::REQ_W-1:0]      s_request_bytes,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tema_pkg::ADDR_W-1:0]     m_block_address,
    output logic [tema_pkg::STATUS_W-1:0]   m_status
);
    import tema_pkg::*;

    localparam int SZ_W = ADDR_W + 1;

    // Configuration registers
    logic [CFG_W-1:0]  base_reg;
    logic [CFG_W-1:0]  region_reg;
    logic [CFG_W-1:0]  new_base;
    logic [CFG_W-1:0]  new_region;
    logic              cfg_wr;

    // Heap pointers
    logic [ADDR_W-1:0] low_ptr_reg;
    logic [ADDR_W-1:0] low_ptr_next;
    logic [ADDR_W-1:0] high_ptr_reg;
    logic [ADDR_W-1:0] high_ptr_next;

    // Input stage
    logic              in_valid_reg;
    op_t               op_reg;
    logic              from_top_reg;
    logic [REQ_W-1:0]  req_reg;

    // Result stage
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    status_t           out_status_reg;
    logic [ADDR_W-1:0] res_addr;
    status_t           res_status;

    // Handshake
    logic              s_fire;
    logic              advance;
    logic              step;

    // Size arithmetic
    logic [SZ_W-1:0]   size_raw;
    logic [SZ_W-1:0]   size_al;
    logic [SZ_W-1:0]   low_end;
    logic [SZ_W-1:0]   high_diff;
    logic              low_wrap;
    logic              low_noroom;
    logic              high_wrap;
    logic              high_noroom;

    // Mark stacks
    stk_cmd_t          lo_cmd;
    stk_cmd_t          hi_cmd;
    stk_stat_t         lo_stat;
    stk_stat_t         hi_stat;
    logic [ADDR_W-1:0] lo_top;
    logic [ADDR_W-1:0] hi_top;

    // APB side
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_REGION) ? region_reg : base_reg;
    assign new_base   = (cfg_wr && paddr[2] == REG_BASE)   ? pwdata : base_reg;
    assign new_region = (cfg_wr && paddr[2] == REG_REGION) ? pwdata : region_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            region_reg <= '0;
        end else if (cfg_wr) begin
            base_reg   <= new_base;
            region_reg <= new_region;
        end
    end

    // Stage control: result register parts the two sides
    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the request beat
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg       <= op_t'(s_op);
            from_top_reg <= s_from_top;
            req_reg      <= s_request_bytes;
        end
    end

    // Round the size up to the alignment and check both ends
    assign size_raw    = SZ_W'(req_reg) + SZ_W'(ALIGN_BYTES - 1);
    assign size_al     = (size_raw >> ALIGN_LOG2) << ALIGN_LOG2;
    assign low_wrap    = size_al > {1'b0, ~low_ptr_reg};
    assign low_end     = {1'b0, low_ptr_reg} + size_al;
    assign low_noroom  = low_end > {1'b0, high_ptr_reg};
    assign high_wrap   = size_al > {1'b0, high_ptr_reg};
    assign high_diff   = {1'b0, high_ptr_reg} - size_al;
    assign high_noroom = high_diff[ADDR_W-1:0] < low_ptr_reg;

    // Decode the operation; state moves only when the stage advances or a register is written
    always_comb begin
        res_addr      = '0;
        res_status    = ST_OK;
        low_ptr_next  = low_ptr_reg;
        high_ptr_next = high_ptr_reg;
        lo_cmd        = '0;
        hi_cmd        = '0;
        case (op_reg)
            OP_ALLOC: begin
                if (req_reg == '0) begin
                    res_status = ST_ZERO;
                end else if (from_top_reg) begin
                    if (high_wrap) begin
                        res_status = ST_WRAP;
                    end else if (high_noroom) begin
                        res_status = ST_NOROOM;
                    end else begin
                        res_addr = high_diff[ADDR_W-1:0];
                        if (step) begin
                            high_ptr_next = high_diff[ADDR_W-1:0];
                        end
                    end
                end else begin
                    if (low_wrap) begin
                        res_status = ST_WRAP;
                    end else if (low_noroom) begin
                        res_status = ST_NOROOM;
                    end else begin
                        res_addr = low_ptr_reg;
                        if (step) begin
                            low_ptr_next = low_end[ADDR_W-1:0];
                        end
                    end
                end
            end
            OP_MARK: begin
                if (from_top_reg) begin
                    if (hi_stat.full) begin
                        res_status = ST_FULL;
                    end else begin
                        hi_cmd.push = step;
                    end
                end else begin
                    if (lo_stat.full) begin
                        res_status = ST_FULL;
                    end else begin
                        lo_cmd.push = step;
                    end
                end
            end
            OP_RELEASE: begin
                if (from_top_reg) begin
                    if (hi_stat.empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        hi_cmd.pop = step;
                        if (step) begin
                            high_ptr_next = hi_top;
                        end
                    end
                end else begin
                    if (lo_stat.empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        lo_cmd.pop = step;
                        if (step) begin
                            low_ptr_next = lo_top;
                        end
                    end
                end
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
        // Re-initialise the heap on any register write
        if (cfg_wr) begin
            low_ptr_next  = ADDR_W'(new_base);
            high_ptr_next = ADDR_W'(new_base) + ADDR_W'(new_region);
            lo_cmd.clear  = 1'b1;
            hi_cmd.clear  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_ptr_reg  <= '0;
            high_ptr_reg <= '0;
        end else begin
            low_ptr_reg  <= low_ptr_next;
            high_ptr_reg <= high_ptr_next;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (step) begin
            out_addr_reg   <= res_addr;
            out_status_reg <= res_status;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_block_address = out_addr_reg;
    assign m_status        = out_status_reg;

    tema_mark_stack u_low_marks (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (lo_cmd),
        .push_data (low_ptr_reg),
        .pop_data  (lo_top),
        .stat      (lo_stat)
    );

    tema_mark_stack u_high_marks (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (hi_cmd),
        .push_data (high_ptr_reg),
        .pop_data  (hi_top),
        .stat      (hi_stat)
    );

    `TEMA_ASSERT_NEXT(a_fail_keeps_ptrs, step && !cfg_wr && res_status != ST_OK, (low_ptr_reg == $past(low_ptr_reg)) && (high_ptr_reg == $past(high_ptr_reg)), "failed request moved a pointer")
    `TEMA_ASSERT_NOW(a_fail_zero_addr, m_valid && m_status != ST_OK, m_block_address == '0, "failed request returned an address")
    `TEMA_ASSERT_NEXT(a_stage_holds, in_valid_reg && !advance, in_valid_reg, "input stage dropped a waiting beat")
    `TEMA_ASSERT_NEXT(a_step_shows, step, out_valid_reg, "computed beat not presented")

endmodule
